@@ sv/bdm_pkg.sv @@
`default_nettype none

package bdm_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 14;
   localparam int WIDTH_W     = 13;
   localparam int HEIGHT_W    = 14;
   localparam int PIXEL_W     = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 14'd480;

   localparam logic [1:0] SLOT_FIRST = 2'd0;
   localparam logic [1:0] SLOT_LAST  = 2'd2;

   typedef struct packed {
      logic       row_odd;
      logic       col_odd;
      logic       row_first;
      logic       col_first;
      logic       row_last;
      logic       col_last;
      logic       frame_last;
      logic       right_ok;
      logic [1:0] slot;
   } pos_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] ul;
      logic [PIXEL_W-1:0] uc;
      logic [PIXEL_W-1:0] ur;
      logic [PIXEL_W-1:0] ml;
      logic [PIXEL_W-1:0] mc;
      logic [PIXEL_W-1:0] mr;
      logic [PIXEL_W-1:0] ll;
      logic [PIXEL_W-1:0] lc;
      logic [PIXEL_W-1:0] lr;
   } win_type;

   function automatic logic [PIXEL_W-1:0] avg2(input logic [PIXEL_W-1:0] a,
                                               input logic [PIXEL_W-1:0] b);
      logic [PIXEL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PIXEL_W:1];
   endfunction

   function automatic logic [1:0] slot_next(input logic [1:0] s);
      return (s == SLOT_LAST) ? SLOT_FIRST : s + 2'd1;
   endfunction

   function automatic logic [1:0] slot_prev(input logic [1:0] s);
      return (s == SLOT_FIRST) ? SLOT_LAST : s - 2'd1;
   endfunction

endpackage

`default_nettype wire

@@ sv/bdm_line_store.sv @@
`default_nettype none

module bdm_line_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [bdm_pkg::PIXEL_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [AW-1:0]               rd_addr_a,
   input  wire logic [AW-1:0]               rd_addr_b,
   output logic      [bdm_pkg::PIXEL_W-1:0] rd_data_a,
   output logic      [bdm_pkg::PIXEL_W-1:0] rd_data_b
);

   logic [bdm_pkg::PIXEL_W-1:0] store_ff [DEPTH];
   logic [bdm_pkg::PIXEL_W-1:0] rd_a_ff;
   logic [bdm_pkg::PIXEL_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // A read of the entry written in the same cycle returns the new sample.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= (wr_en && wr_addr == rd_addr_a) ? wr_data : store_ff[rd_addr_a];
         rd_b_ff <= (wr_en && wr_addr == rd_addr_b) ? wr_data : store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

@@ sv/bdm_ctrl.sv @@
`default_nettype none

module bdm_ctrl #(
   parameter int LINE_DEPTH = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [bdm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bdm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            accept,
   input  wire logic                            drain,
   input  wire logic [bdm_pkg::PIXEL_W-1:0]     pixel,
   output logic                                 wr_en,
   output logic      [1:0]                      wr_slot,
   output logic      [$clog2(LINE_DEPTH)-1:0]   wr_addr,
   output logic      [bdm_pkg::PIXEL_W-1:0]     wr_data,
   output logic                                 rd_en,
   output logic      [$clog2(LINE_DEPTH)-1:0]   rd_addr_center,
   output logic      [$clog2(LINE_DEPTH)-1:0]   rd_addr_right,
   output bdm_pkg::pos_type                     pos
);

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int CW = $clog2(LINE_DEPTH + 1);
   localparam int EW = (CW > bdm_pkg::WIDTH_W) ? CW : bdm_pkg::WIDTH_W;
   localparam int RW = bdm_pkg::HEIGHT_W;
   localparam int PW = CW + RW + 1;

   logic [bdm_pkg::WIDTH_W-1:0]  width_ff;
   logic [bdm_pkg::HEIGHT_W-1:0] height_ff;
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [PW-1:0] pending_ff, pending_in;
   logic [1:0]    in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;

   logic [EW-1:0] width_ext;
   logic [EW-1:0] width_clamp;
   logic [CW-1:0] eff_w;
   logic [RW-1:0] eff_h;
   logic [PW-1:0] pending_next;
   logic [PW-1:0] row_base;
   logic [PW-1:0] in_frame;
   logic          pix;
   logic          emit;

   always_comb begin
      width_ext = EW'(width_ff);
      if (width_ext < EW'(4)) begin
         width_clamp = EW'(4);
      end else if (width_ext > EW'(LINE_DEPTH)) begin
         width_clamp = EW'(LINE_DEPTH);
      end else begin
         width_clamp = width_ext;
      end
      eff_w = CW'(width_clamp) & ~CW'(1);
      if (height_ff < RW'(4)) begin
         eff_h = RW'(4);
      end else begin
         eff_h = height_ff & ~RW'(1);
      end
   end

   // The input position within the frame is taken from the row and column at the
   // current size, so it stays consistent after a size change.
   always_comb begin
      pix        = accept && !drain;
      row_base   = PW'(in_row_ff - RW'(1)) * PW'(eff_w);
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      in_slot_in = in_slot_ff;
      in_frame   = row_base + PW'(in_col_ff - CW'(1));
      if (pix) begin
         if (in_col_ff >= eff_w) begin
            in_col_in  = CW'(1);
            in_slot_in = bdm_pkg::slot_next(in_slot_ff);
            if (in_row_ff >= eff_h) begin
               in_row_in = RW'(1);
               in_frame  = '0;
            end else begin
               in_row_in = in_row_ff + RW'(1);
               in_frame  = row_base + PW'(eff_w);
            end
         end else begin
            in_col_in = in_col_ff + CW'(1);
            in_frame  = row_base + PW'(in_col_ff);
         end
      end
      pending_next = pending_ff + PW'(pix);
      emit = accept && (pending_next != '0)
             && ((pending_next > in_frame)
                 || (pix && pending_next >= PW'(eff_w) + PW'(2)));
      pending_in = pending_next - PW'(emit);
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_slot_in = out_slot_ff;
      if (emit) begin
         if (out_col_ff >= eff_w) begin
            out_col_in  = CW'(1);
            out_slot_in = bdm_pkg::slot_next(out_slot_ff);
            out_row_in  = (out_row_ff >= eff_h) ? RW'(1) : out_row_ff + RW'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bdm_pkg::WIDTH_RESET;
         height_ff    <= bdm_pkg::HEIGHT_RESET;
         in_row_ff    <= RW'(1);
         in_col_ff    <= CW'(1);
         out_row_ff   <= RW'(1);
         out_col_ff   <= CW'(1);
         pending_ff   <= '0;
         in_slot_ff   <= bdm_pkg::SLOT_FIRST;
         out_slot_ff  <= bdm_pkg::SLOT_FIRST;
      end else begin
         if (csr_wr_en && csr_index == bdm_pkg::REG_FRAME_WIDTH) begin
            width_ff <= csr_wdata[bdm_pkg::WIDTH_W-1:0];
         end
         if (csr_wr_en && csr_index == bdm_pkg::REG_FRAME_HEIGHT) begin
            height_ff <= csr_wdata[bdm_pkg::HEIGHT_W-1:0];
         end
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         pending_ff   <= pending_in;
         in_slot_ff   <= in_slot_in;
         out_slot_ff  <= out_slot_in;
      end
   end

   always_comb begin
      wr_en          = pix && (in_col_ff != '0) && (in_col_ff <= CW'(LINE_DEPTH));
      wr_slot        = in_slot_ff;
      wr_addr        = AW'(in_col_ff - CW'(1));
      wr_data        = pixel;
      rd_en          = emit;
      rd_addr_center = AW'(out_col_ff - CW'(1));
      rd_addr_right  = out_col_ff[AW-1:0];
      pos.row_odd    = out_row_ff[0];
      pos.col_odd    = out_col_ff[0];
      pos.row_first  = (out_row_ff == RW'(1));
      pos.col_first  = (out_col_ff == CW'(1));
      pos.row_last   = (out_row_ff >= eff_h);
      pos.col_last   = (out_col_ff >= eff_w);
      pos.frame_last = (out_row_ff == eff_h) && (out_col_ff == eff_w);
      pos.right_ok   = (out_col_ff < CW'(LINE_DEPTH));
      pos.slot       = out_slot_ff;
   end

endmodule

`default_nettype wire

@@ sv/bdm_interp.sv @@
`default_nettype none

module bdm_interp (
   input  wire bdm_pkg::win_type            win,
   input  wire bdm_pkg::pos_type            pos,
   output logic [bdm_pkg::PIXEL_W-1:0]      red,
   output logic [bdm_pkg::PIXEL_W-1:0]      green,
   output logic [bdm_pkg::PIXEL_W-1:0]      blue
);

   logic [bdm_pkg::PIXEL_W-1:0] blue_up, blue_mid, blue_low;
   logic [bdm_pkg::PIXEL_W-1:0] red_up, red_mid, red_low;
   logic [bdm_pkg::PIXEL_W+1:0] sum4;

   always_comb begin
      if (pos.col_first) begin
         blue_up  = win.ur;
         blue_mid = win.mr;
         blue_low = win.lr;
      end else if (!pos.col_odd) begin
         blue_up  = win.uc;
         blue_mid = win.mc;
         blue_low = win.lc;
      end else begin
         blue_up  = bdm_pkg::avg2(win.ul, win.ur);
         blue_mid = bdm_pkg::avg2(win.ml, win.mr);
         blue_low = bdm_pkg::avg2(win.ll, win.lr);
      end
      if (!pos.row_odd) begin
         blue = blue_mid;
      end else if (pos.row_first) begin
         blue = blue_low;
      end else begin
         blue = bdm_pkg::avg2(blue_up, blue_low);
      end

      if (pos.col_last) begin
         red_up  = win.ul;
         red_mid = win.ml;
         red_low = win.ll;
      end else if (pos.col_odd) begin
         red_up  = win.uc;
         red_mid = win.mc;
         red_low = win.lc;
      end else begin
         red_up  = bdm_pkg::avg2(win.ul, win.ur);
         red_mid = bdm_pkg::avg2(win.ml, win.mr);
         red_low = bdm_pkg::avg2(win.ll, win.lr);
      end
      if (pos.row_odd) begin
         red = red_mid;
      end else if (pos.row_last) begin
         red = red_up;
      end else begin
         red = bdm_pkg::avg2(red_up, red_low);
      end

      sum4 = 10'(win.ml) + 10'(win.mr) + 10'(win.uc) + 10'(win.lc);
      if (pos.row_odd != pos.col_odd) begin
         green = win.mc;
      end else if (pos.row_odd && pos.row_first && pos.col_first) begin
         green = bdm_pkg::avg2(win.mr, win.lc);
      end else if (pos.row_odd && pos.row_first) begin
         green = bdm_pkg::avg2(win.ml, win.mr);
      end else if (pos.row_odd && pos.col_first) begin
         green = bdm_pkg::avg2(win.uc, win.lc);
      end else if (!pos.row_odd && pos.row_last && pos.col_last) begin
         green = bdm_pkg::avg2(win.uc, win.ml);
      end else if (!pos.row_odd && pos.row_last) begin
         green = bdm_pkg::avg2(win.ml, win.mr);
      end else if (!pos.row_odd && pos.col_last) begin
         green = bdm_pkg::avg2(win.uc, win.lc);
      end else begin
         green = sum4[bdm_pkg::PIXEL_W+1:2];
      end
   end

endmodule

`default_nettype wire

@@ sv/bilinear_bayer_demosaic_top.sv @@
`default_nettype none

// Bilinear demosaic of an RGGB raw stream, 8 bits per sample, one request per clock cycle
// while the output is not stalled. Each accepted pixel is written into one of three line
// memories used in rotation. A result, when one is due, passes the memory read register
// and then the output register: the clock edge that accepts the request releasing it loads
// the registered memory read of the two new columns, and the output register then loads
// the interpolated color once it is free. Results run about one row and one pixel behind
// the input, so the last row and a pixel of a frame leave only when the next frame starts
// or drain requests arrive, one result per drain request. Rate is set by the single write
// and two read ports of each line memory, which allow one pixel in and one result out per cycle.
module bilinear_bayer_demosaic_top #(
   parameter int LINE_DEPTH = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // raw_pixel
   input  wire logic                            req_tuser,   // drain
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [23:0]                     rsp_tdata,   // blue, green, red
   output logic                                 rsp_tlast,   // frame_last
   input  wire logic                            csr_wr_en,
   input  wire logic [bdm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bdm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int PX = bdm_pkg::PIXEL_W;

   logic                 accept;
   logic                 wr_en;
   logic [1:0]           wr_slot;
   logic [AW-1:0]        wr_addr;
   logic [PX-1:0]        wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr_center;
   logic [AW-1:0]        rd_addr_right;
   bdm_pkg::pos_type     pos;
   logic [PX-1:0]        center_q [3];
   logic [PX-1:0]        right_q [3];

   logic                 s1_valid_ff, s1_valid_in;
   bdm_pkg::pos_type     s1_pos_ff;
   logic [PX-1:0]        prev_up_ff, prev_mid_ff, prev_low_ff;
   logic                 s2_ready;
   logic                 s1_adv;
   logic [1:0]           up_slot, low_slot;
   bdm_pkg::win_type     win;
   logic [PX-1:0]        red, green, blue;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [23:0]          rsp_data_ff;
   logic                 rsp_last_ff;

   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && s2_ready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign accept     = req_tvalid && req_tready;

   bdm_ctrl #(.LINE_DEPTH(LINE_DEPTH)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .accept         (accept),
      .drain          (req_tuser),
      .pixel          (req_tdata),
      .wr_en          (wr_en),
      .wr_slot        (wr_slot),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_en          (rd_en),
      .rd_addr_center (rd_addr_center),
      .rd_addr_right  (rd_addr_right),
      .pos            (pos)
   );

   for (genvar k = 0; k < 3; k++) begin : g_store
      bdm_line_store #(.DEPTH(LINE_DEPTH), .AW(AW)) u_store (
         .clock     (clock),
         .wr_en     (wr_en && wr_slot == 2'(k)),
         .wr_addr   (wr_addr),
         .wr_data   (wr_data),
         .rd_en     (rd_en),
         .rd_addr_a (rd_addr_center),
         .rd_addr_b (rd_addr_right),
         .rd_data_a (center_q[k]),
         .rd_data_b (right_q[k])
      );
   end

   always_comb begin
      up_slot  = bdm_pkg::slot_prev(s1_pos_ff.slot);
      low_slot = bdm_pkg::slot_next(s1_pos_ff.slot);
      win.uc = center_q[up_slot];
      win.mc = center_q[s1_pos_ff.slot];
      win.lc = center_q[low_slot];
      win.ur = s1_pos_ff.right_ok ? right_q[up_slot] : '0;
      win.mr = s1_pos_ff.right_ok ? right_q[s1_pos_ff.slot] : '0;
      win.lr = s1_pos_ff.right_ok ? right_q[low_slot] : '0;
      win.ul = s1_pos_ff.col_first ? '0 : prev_up_ff;
      win.ml = s1_pos_ff.col_first ? '0 : prev_mid_ff;
      win.ll = s1_pos_ff.col_first ? '0 : prev_low_ff;
   end

   bdm_interp u_interp (
      .win   (win),
      .pos   (s1_pos_ff),
      .red   (red),
      .green (green),
      .blue  (blue)
   );

   always_comb begin
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_pos_ff <= pos;
      end
      if (s1_adv) begin
         prev_up_ff  <= win.uc;
         prev_mid_ff <= win.mc;
         prev_low_ff <= win.lc;
         rsp_data_ff <= {blue, green, red};
         rsp_last_ff <= s1_pos_ff.frame_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
